// ----- hw/rtl/sha1_message_digest_defines.svh -----
// Assertion macros used by the SHA-1 digest controller RTL.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define SHA1_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sha1 same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define SHA1_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sha1 next-cycle check failed");

`endif

// ----- hw/rtl/sha1_pkg.sv -----
// Shared types, constants and control structs of the SHA-1 digest block.
package sha1_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CHAIN_N = 5;
    localparam int unsigned WIN_N   = 16;
    localparam int unsigned ROUND_W = 7;
    localparam int unsigned FILL_W  = 6;
    localparam int unsigned MSG_W   = 61;
    localparam int unsigned OUT_W   = 3;
    localparam int unsigned LEN_W   = 3;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word IV [CHAIN_N] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [ROUND_W-1:0] ROUND_B1   = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_B2   = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_B3   = 7'd60;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

    localparam logic [FILL_W-1:0] FILL_LAST    = 6'd63;
    localparam logic [FILL_W-1:0] FILL_PAD_END = 6'd56;

    localparam logic [OUT_W-1:0] OUT_LAST = 3'd4;
    localparam logic [LEN_W-1:0] LEN_LAST = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_COMPRESS,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic               byte_we;
        t_byte_sel          byte_sel;
        logic [LEN_W-1:0]   len_idx;
        logic               msg_inc;
        logic               round_en;
        logic [ROUND_W-1:0] round;
        logic               chain_add;
        logic               restart;
        logic [OUT_W-1:0]   out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_last;
        logic fill_pad_end;
    } t_dp_stat;

endpackage

// ----- hw/rtl/sha1_if.sv -----
// Handshake interfaces for the message byte and digest word channels.
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic        last_word;

    modport source (output valid, digest_word, last_word, input ready);
    modport sink   (input valid, digest_word, last_word, output ready);
endinterface

// ----- hw/rtl/sha1_dp.sv -----
// SHA-1 datapath: byte packing, message schedule window, round logic, chaining words.
module sha1_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_data_byte,
    input  sha1_pkg::t_dp_cmd i_cmd,
    output sha1_pkg::t_dp_stat o_stat,
    output sha1_pkg::t_word   o_digest_word
);
    import sha1_pkg::*;

    t_word             r_chain [CHAIN_N];
    t_word             n_chain [CHAIN_N];
    t_word             r_work  [CHAIN_N];
    t_word             n_work  [CHAIN_N];
    t_word             r_win   [WIN_N];
    t_word             n_win   [WIN_N];
    logic [23:0]       r_acc;
    logic [23:0]       n_acc;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [MSG_W-1:0]  r_msg;
    logic [MSG_W-1:0]  n_msg;

    logic [7:0]  wr_byte;
    logic [63:0] len_bits;
    logic [63:0] len_sh;
    t_word       sched;
    t_word       f_val;
    t_word       k_val;
    t_word       t_val;

    always_comb begin
        len_bits = {r_msg, 3'b000};
        len_sh   = len_bits >> {3'(LEN_LAST - i_cmd.len_idx), 3'b000};
        unique case (i_cmd.byte_sel)
            SEL_DATA: wr_byte = i_data_byte;
            SEL_PAD:  wr_byte = PAD_BYTE;
            SEL_ZERO: wr_byte = 8'h00;
            SEL_LEN:  wr_byte = len_sh[7:0];
            default:  wr_byte = 8'h00;
        endcase
    end

    always_comb begin
        sched = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        sched = {sched[30:0], sched[31]};
        priority if (i_cmd.round < ROUND_B1) begin
            f_val = (r_work[1] & r_work[2]) | (~r_work[1] & r_work[3]);
            k_val = K0;
        end else if (i_cmd.round < ROUND_B2) begin
            f_val = r_work[1] ^ r_work[2] ^ r_work[3];
            k_val = K1;
        end else if (i_cmd.round < ROUND_B3) begin
            f_val = (r_work[1] & r_work[2]) | (r_work[1] & r_work[3])
                  | (r_work[2] & r_work[3]);
            k_val = K2;
        end else begin
            f_val = r_work[1] ^ r_work[2] ^ r_work[3];
            k_val = K3;
        end
        t_val = {r_work[0][26:0], r_work[0][31:27]} + f_val + r_work[4] + k_val + r_win[0];
    end

    always_comb begin
        n_chain = r_chain;
        n_work  = r_work;
        n_win   = r_win;
        n_acc   = r_acc;
        n_fill  = r_fill;
        n_msg   = r_msg;

        if (i_cmd.byte_we) begin
            n_fill = r_fill + 6'd1;
            n_acc  = {r_acc[15:0], wr_byte};
            if (r_fill[1:0] == 2'b11) begin
                for (int i = 0; i < WIN_N - 1; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[WIN_N-1] = {r_acc, wr_byte};
            end
        end

        if (i_cmd.msg_inc) begin
            n_msg = r_msg + 61'd1;
        end

        if (i_cmd.round_en) begin
            for (int i = 0; i < WIN_N - 1; i++) begin
                n_win[i] = r_win[i+1];
            end
            n_win[WIN_N-1] = sched;
            n_work[0] = t_val;
            n_work[1] = r_work[0];
            n_work[2] = {r_work[1][1:0], r_work[1][31:2]};
            n_work[3] = r_work[2];
            n_work[4] = r_work[3];
        end

        if (i_cmd.chain_add) begin
            for (int i = 0; i < CHAIN_N; i++) begin
                n_chain[i] = r_chain[i] + r_work[i];
                n_work[i]  = r_chain[i] + r_work[i];
            end
        end

        if (i_cmd.restart) begin
            n_chain = IV;
            n_work  = IV;
            n_fill  = '0;
            n_msg   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= IV;
            r_work  <= IV;
            r_fill  <= '0;
            r_msg   <= '0;
        end else begin
            r_chain <= n_chain;
            r_work  <= n_work;
            r_fill  <= n_fill;
            r_msg   <= n_msg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_acc <= n_acc;
    end

    assign o_stat.fill_last    = (r_fill == FILL_LAST);
    assign o_stat.fill_pad_end = (r_fill == FILL_PAD_END);
    assign o_digest_word       = r_chain[i_cmd.out_idx];

endmodule

// ----- hw/rtl/sha1_ctrl.sv -----
// SHA-1 controller: input acceptance, padding sequence, round count and digest output.
`include "sha1_message_digest_defines.svh"

module sha1_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_has_byte,
    input  logic               i_end_of_message,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_last_word,
    input  sha1_pkg::t_dp_stat i_stat,
    output sha1_pkg::t_dp_cmd  o_cmd
);
    import sha1_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_state             r_ret;
    t_state             n_ret;
    logic [ROUND_W-1:0] r_round;
    logic [ROUND_W-1:0] n_round;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   n_len;
    logic [OUT_W-1:0]   r_out;
    logic [OUT_W-1:0]   n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_round <= '0;
            r_len   <= '0;
            r_out   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_round <= n_round;
            r_len   <= n_len;
            r_out   <= n_out;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_round     = r_round;
        n_len       = r_len;
        n_out       = r_out;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.byte_sel = SEL_DATA;
        o_cmd.len_idx  = r_len;
        o_cmd.round    = r_round;
        o_cmd.out_idx  = r_out;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_has_byte) begin
                        o_cmd.byte_we = 1'b1;
                        o_cmd.msg_inc = 1'b1;
                    end
                    if (i_has_byte && i_stat.fill_last) begin
                        n_state = ST_COMPRESS;
                        n_ret   = i_end_of_message ? ST_PAD80 : ST_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                o_cmd.byte_we  = 1'b1;
                o_cmd.byte_sel = SEL_PAD;
                if (i_stat.fill_last) begin
                    n_state = ST_COMPRESS;
                    n_ret   = ST_PADZ;
                end else begin
                    n_state = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (i_stat.fill_pad_end) begin
                    n_state = ST_PADLEN;
                end else begin
                    o_cmd.byte_we  = 1'b1;
                    o_cmd.byte_sel = SEL_ZERO;
                    if (i_stat.fill_last) begin
                        n_state = ST_COMPRESS;
                        n_ret   = ST_PADZ;
                    end
                end
            end
            ST_PADLEN: begin
                o_cmd.byte_we  = 1'b1;
                o_cmd.byte_sel = SEL_LEN;
                n_len          = r_len + 3'd1;
                if (r_len == LEN_LAST) begin
                    n_state = ST_COMPRESS;
                    n_ret   = ST_EMIT;
                end
            end
            ST_COMPRESS: begin
                o_cmd.round_en = 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_round = '0;
                    n_state = ST_UPDATE;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            ST_UPDATE: begin
                o_cmd.chain_add = 1'b1;
                n_state         = r_ret;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_out == OUT_LAST) begin
                        o_cmd.restart = 1'b1;
                        n_out         = '0;
                        n_state       = ST_IDLE;
                    end else begin
                        n_out = r_out + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_last_word = (r_out == OUT_LAST);

    `SHA1_ASSERT_NEXT(a_round_done, (r_state == ST_COMPRESS) && (r_round == ROUND_LAST), r_state == ST_UPDATE)
    `SHA1_ASSERT_SAME(a_round_clear, r_state != ST_COMPRESS, r_round == '0)
    `SHA1_ASSERT_NEXT(a_len_done, (r_state == ST_PADLEN) && (r_len == LEN_LAST), (r_state == ST_COMPRESS) && (r_ret == ST_EMIT))
    `SHA1_ASSERT_NEXT(a_emit_done, o_out_valid && i_out_ready && o_last_word, r_state == ST_IDLE)
    `SHA1_ASSERT_NEXT(a_block_full, o_in_ready && i_in_valid && i_has_byte && i_stat.fill_last, r_state == ST_COMPRESS)

endmodule

// ----- hw/rtl/sha1_message_digest.sv -----
// Top level: SHA-1 digest of a byte stream, at most one message byte per transaction.
// Input: bytes are taken only in the idle state; a byte that fills a 64-byte block is
//   followed by 80 rounds and one chaining update, during which no input is taken.
// End of message: the 0x80 pad byte, zero bytes up to byte 56, an idle step before the
//   length, the eight length bytes, the rounds and update for each block, then 5 digest words.
// Reset: synchronous, active low; loads the initial hash words and clears all counters.
module sha1_message_digest (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sha1_in_if.sink   i_msg,
    sha1_out_if.source o_digest
);
    import sha1_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sha1_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_msg.valid),
        .i_has_byte       (i_msg.has_byte),
        .i_end_of_message (i_msg.end_of_message),
        .o_in_ready       (i_msg.ready),
        .o_out_valid      (o_digest.valid),
        .i_out_ready      (o_digest.ready),
        .o_last_word      (o_digest.last_word),
        .i_stat           (dp_stat),
        .o_cmd            (dp_cmd)
    );

    sha1_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_msg.data_byte),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_digest_word (o_digest.digest_word)
    );

endmodule

// ----- verif/sha1_message_digest_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the SHA-1 digest block: random byte messages, digests checked in order.
module sha1_message_digest_tb;
    import sha1_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned ITEM_TARGET  = 180;
    localparam int unsigned HOLD_START   = 600;
    localparam int unsigned HOLD_LEN     = 800;
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned REPORT_MAX   = 10;

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] LEN_FIELD_AT = 6'd56;

    localparam t_word H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam t_word K_ROUND [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };
    localparam int EDGE_LEN [6] = '{55, 56, 57, 63, 64, 119};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_msg_item;

    typedef struct packed {
        t_word word;
        logic  last;
    } t_digest_word;

    logic i_clk;
    logic i_rst_n;

    sha1_in_if  msg_if ();
    sha1_out_if dig_if ();

    sha1_message_digest i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_msg    (msg_if),
        .o_digest (dig_if)
    );

    t_word        chain_h [5];
    t_word        blk_w [16];
    logic [5:0]   blk_fill;
    logic [60:0]  msg_len;

    t_msg_item    pend_q [$];
    t_digest_word expected_digest_q [$];

    int unsigned  n_items;
    int unsigned  n_total;
    int unsigned  n_accepted = 0;
    int unsigned  n_msgs     = 0;
    int unsigned  n_words    = 0;
    int unsigned  n_errors   = 0;
    int unsigned  cycle_cnt  = 0;
    int unsigned  hold_left;
    int           tx_gap;
    int           rx_gap;

    function automatic void sha_restart();
        int i;
        for (i = 0; i < 5; i++) chain_h[i] = H_INIT[i];
        blk_fill = '0;
        msg_len  = '0;
    endfunction

    function automatic void sha_compress_block();
        t_word w [16];
        t_word a, b, c, d, e, f, k, wr, t;
        int r;
        for (r = 0; r < 16; r++) w[r] = blk_w[r];
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (r = 0; r < 80; r++) begin
            if (r < 16) begin
                wr = w[r];
            end else begin
                wr = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
                wr = {wr[30:0], wr[31]};
                w[r % 16] = wr;
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_ROUND[0];
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND[1];
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND[2];
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND[3];
            end
            t = {a[26:0], a[31:27]} + f + e + k + wr;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void sha_absorb_byte(input logic [7:0] bt);
        int sh;
        sh = 8 * (3 - int'(blk_fill[1:0]));
        blk_w[blk_fill[5:2]][sh +: 8] = bt;
        blk_fill = blk_fill + 6'd1;
        if (blk_fill == 6'd0) sha_compress_block();
    endfunction

    function automatic void sha_take_item(input t_msg_item it);
        logic [63:0] bit_len;
        t_digest_word dw;
        int i;
        if (it.has_byte) begin
            sha_absorb_byte(it.data_byte);
            msg_len = msg_len + 61'd1;
        end
        if (it.end_of_message) begin
            bit_len = {msg_len, 3'b000};
            sha_absorb_byte(PAD_MARK);
            while (blk_fill != LEN_FIELD_AT) sha_absorb_byte(8'h00);
            for (i = 0; i < 8; i++) sha_absorb_byte(bit_len[63 - 8 * i -: 8]);
            for (i = 0; i < 5; i++) begin
                dw = '{word: chain_h[i], last: (i == 4)};
                expected_digest_q = {expected_digest_q, dw};
            end
            sha_restart();
            n_msgs++;
        end
    endfunction

    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_item(input logic [7:0] bt, input logic has, input logic eom);
        t_msg_item it;
        it = '{data_byte: bt, has_byte: has, end_of_message: eom};
        pend_q = {pend_q, it};
        if (has || eom) n_items++;
    endfunction

    function automatic void add_message(input int len);
        int i;
        int pat;
        logic glue_end;
        logic [7:0] bt;
        pat = $urandom_range(0, 9);
        glue_end = (len > 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 8) add_item(8'($urandom), 1'b0, 1'b0);
            bt = (pat == 0) ? 8'h00 : (pat == 1) ? 8'hFF : 8'($urandom);
            add_item(bt, 1'b1, glue_end && (i == len - 1));
        end
        if (!glue_end) add_item(8'($urandom), 1'b0, 1'b1);
    endfunction

    function automatic void flag_mismatch(input string what, input t_word want, input t_word got);
        n_errors++;
        if (n_errors <= REPORT_MAX)
            $display("ERROR: %s at cycle %0d: expected %08h, got %08h",
                     what, cycle_cnt, want, got);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // Hold off the digest side for a long stretch while bytes keep coming.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (cycle_cnt == HOLD_START) begin
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            msg_if.valid          <= 1'b0;
            msg_if.data_byte      <= '0;
            msg_if.has_byte       <= 1'b0;
            msg_if.end_of_message <= 1'b0;
            tx_gap = 0;
            sha_restart();
        end else begin
            if (msg_if.valid && msg_if.ready) begin
                sha_take_item('{data_byte: msg_if.data_byte, has_byte: msg_if.has_byte,
                                end_of_message: msg_if.end_of_message});
                n_accepted++;
            end
            if (!msg_if.valid || msg_if.ready) begin
                if (tx_gap > 0) begin
                    msg_if.valid <= 1'b0;
                    tx_gap--;
                end else if (pend_q.size() > 0) begin
                    msg_if.valid          <= 1'b1;
                    msg_if.data_byte      <= pend_q[0].data_byte;
                    msg_if.has_byte       <= pend_q[0].has_byte;
                    msg_if.end_of_message <= pend_q[0].end_of_message;
                    void'(pend_q.pop_front());
                    tx_gap = draw_gap();
                end else begin
                    msg_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_digest_word want;
        if (!i_rst_n) begin
            dig_if.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (dig_if.valid && dig_if.ready) begin
                n_words++;
                if (expected_digest_q.size() == 0) begin
                    flag_mismatch("unexpected digest word", '0, dig_if.digest_word);
                end else begin
                    want = expected_digest_q.pop_front();
                    if (dig_if.digest_word !== want.word)
                        flag_mismatch("digest_word", want.word, dig_if.digest_word);
                    if (dig_if.last_word !== want.last)
                        flag_mismatch("last_word", t_word'(want.last),
                                      t_word'(dig_if.last_word));
                end
            end
            if (hold_left != 0) begin
                dig_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                dig_if.ready <= 1'b0;
                rx_gap--;
            end else begin
                dig_if.ready <= 1'b1;
                rx_gap = draw_gap();
            end
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int p;
        int len;
        i_rst_n = 1'b0;
        n_items = 0;

        // empty message, twice in a row
        add_item(8'h00, 1'b0, 1'b1);
        add_item(8'hFF, 1'b0, 1'b1);
        // idle transaction with garbage data
        add_item(8'hA5, 1'b0, 1'b0);
        // "abc" with the end riding on the last byte
        add_item(8'h61, 1'b1, 1'b0);
        add_item(8'h62, 1'b1, 1'b0);
        add_item(8'h63, 1'b1, 1'b1);
        // extreme bytes, then an idle transaction and a standalone end carrying ignored data
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(8'h5A, 1'b0, 1'b0);
        add_item(8'h5A, 1'b0, 1'b1);
        // single pad-valued byte ending its message, then a two-byte message
        add_item(PAD_MARK, 1'b1, 1'b1);
        add_item(8'h7F, 1'b1, 1'b0);
        add_item(8'h01, 1'b1, 1'b1);

        while (n_items < ITEM_TARGET) begin
            p = $urandom_range(0, 99);
            if (p < 72) len = $urandom_range(0, 10);
            else if (p < 93) len = EDGE_LEN[$urandom_range(0, 5)];
            else len = $urandom_range(11, 130);
            if (len > int'(ITEM_TARGET - n_items)) len = int'(ITEM_TARGET - n_items);
            add_message(len);
        end
        n_total = pend_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted == n_total);
        wait (expected_digest_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d transactions (%0d with a byte or an end) hashed into %0d messages",
                 n_total, n_items, n_msgs);
        $display("summary: %0d digest words checked, %0d mismatches", n_words, n_errors);
        if (n_errors == 0 && expected_digest_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
